>>> hw/rtl/bcls_pkg.sv
// ----------------------------------------------------------------------------
// bcls_pkg
// Shared types and constants of the advertising beacon classifier.
// ----------------------------------------------------------------------------
package bcls_pkg;

   // parse phase codes
   localparam logic [1:0] PH_LEN  = 2'd0;
   localparam logic [1:0] PH_TYPE = 2'd1;
   localparam logic [1:0] PH_SKIP = 2'd2;

   // structure type codes
   localparam logic [7:0] TYPE_SHORT_NAME = 8'h08;
   localparam logic [7:0] TYPE_FULL_NAME  = 8'h09;
   localparam logic [7:0] TYPE_MANUF      = 8'hFF;

   // manufacturer record match values
   localparam logic [15:0] COMPANY_CODE = 16'h004C;
   localparam logic [15:0] KIND_CODE    = 16'h1502;
   localparam logic [7:0]  MANUF_LEN    = 8'h19;

   // capture offsets within the manufacturer data
   localparam int          CAP_POS_W      = 5;
   localparam logic [4:0]  CAPTURE_LEN    = 5'd25;
   localparam logic [4:0]  CAP_COMPANY_LO = 5'd0;
   localparam logic [4:0]  CAP_COMPANY_HI = 5'd1;
   localparam logic [4:0]  CAP_KIND_LO    = 5'd2;
   localparam logic [4:0]  CAP_KIND_HI    = 5'd3;
   localparam logic [4:0]  CAP_MAJOR_LO   = 5'd21;
   localparam logic [4:0]  CAP_MINOR_HI   = 5'd22;
   localparam logic [4:0]  CAP_MINOR_LO   = 5'd23;

   // result queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef struct packed {
      logic signed [7:0] report_dbm;
      logic [7:0]        group_code;
      logic [15:0]       beacon_ident;
   } bcls_item_type;

   typedef struct packed {
      logic                   full;
      logic                   not_empty;
      logic [QUEUE_CNT_W-1:0] count;
   } q_stat_type;

endpackage

>>> hw/rtl/bcls_req_if.sv
// ----------------------------------------------------------------------------
// bcls_req_if
// Input channel: one advertising byte per beat.
// ----------------------------------------------------------------------------
interface bcls_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        data_byte;
   logic signed [7:0] signal_dbm;
   logic              last_byte;

   modport source (output valid, data_byte, signal_dbm, last_byte, input ready);
   modport sink   (input valid, data_byte, signal_dbm, last_byte, output ready);
endinterface

>>> hw/rtl/bcls_rsp_if.sv
// ----------------------------------------------------------------------------
// bcls_rsp_if
// Result channel: one beacon report per beat.
// ----------------------------------------------------------------------------
interface bcls_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] report_dbm;
   logic [7:0]        group_code;
   logic [15:0]       beacon_ident;

   modport source (output valid, report_dbm, group_code, beacon_ident, input ready);
   modport sink   (input valid, report_dbm, group_code, beacon_ident, output ready);
endinterface

>>> hw/rtl/ble_adv_beacon_classifier_unit.sv
// Path: a report from the last byte is written into the queue, then loaded
// into the output register that drives rsp valid, once that register is free.
// Throughput: one advertising byte per cycle; the walker updates in one step.
// Input stalls only when the two-entry report queue is full.
// Reset (synchronous, active high) clears parse state, queue and output valid;
// the signal threshold returns to -128 dBm.
// ----------------------------------------------------------------------------
// ble_adv_beacon_classifier_unit
// Advertising report parser that emits beacon reports above a signal floor.
// ----------------------------------------------------------------------------
module ble_adv_beacon_classifier_unit (
   input  logic              clock,
   input  logic              reset,
   bcls_req_if.sink          req_port,
   bcls_rsp_if.source        rsp_port,
   input  logic              csr_write_enable,
   input  logic signed [7:0] csr_write_data
);
   import bcls_pkg::*;

   // threshold register; the user must write it only while idle (not enforced here)
   logic signed [7:0] min_rssi_ff, min_rssi_in;

   // front to queue
   logic          push_valid;
   bcls_item_type push_item;

   // queue to back
   logic          pop;
   bcls_item_type pop_item;
   q_stat_type    q_stat;

   assign min_rssi_in = csr_write_enable ? csr_write_data : min_rssi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_rssi_ff <= 8'sh80;
      end else begin
         min_rssi_ff <= min_rssi_in;
      end
   end

   // front: walks each beat, decides on the last beat of a report
   bcls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .min_rssi   (min_rssi_ff),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // queue: lets the walker keep going while a report waits downstream
   bcls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .pop_item   (pop_item),
      .q_stat     (q_stat)
   );

   // back: registered result beat
   bcls_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

`ifndef NO_ASSERTIONS
   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && q_stat.full))
      else $error("report pushed into a full queue");

   // only a last byte can produce a report
   a_push_on_last: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (req_port.valid && req_port.ready && req_port.last_byte))
      else $error("report pushed without a last byte");

   // a result beat is withdrawn only after it was taken
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_port.valid) && !$past(reset)) |-> $past(rsp_port.ready))
      else $error("result beat dropped before handshake");

   // a nonempty queue with a free output register is drained
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (q_stat.not_empty && !rsp_port.valid) |=> rsp_port.valid)
      else $error("queued report not moved to output");
`endif

endmodule

>>> hw/rtl/bcls_front.sv
// ----------------------------------------------------------------------------
// bcls_front
// Byte walker: parses length/type structures, captures manufacturer data,
// and pushes a report into the queue on a qualifying last byte.
// ----------------------------------------------------------------------------
module bcls_front (
   input  logic                   clock,
   input  logic                   reset,
   bcls_req_if.sink               req_port,
   input  logic signed [7:0]      min_rssi,
   input  bcls_pkg::q_stat_type   q_stat,
   output logic                   push_valid,
   output bcls_pkg::bcls_item_type push_item
);
   import bcls_pkg::*;

   logic [1:0]           phase_ff, phase_in;
   logic [7:0]           left_ff, left_in;
   logic                 name_seen_ff, name_seen_in;
   logic                 manuf_seen_ff, manuf_seen_in;
   logic [7:0]           manuf_len_ff, manuf_len_in;
   logic [CAP_POS_W-1:0] pos_ff, pos_in;
   logic [15:0]          company_ff, company_in;
   logic [15:0]          kind_ff, kind_in;
   logic [7:0]           major_ff, major_in;
   logic [15:0]          minor_ff, minor_in;
   logic                 walk_done_ff, walk_done_in;
   logic                 accept;
   logic                 ok;
   logic [7:0]           b;
   logic [7:0]           rep_major;
   logic [15:0]          rep_minor;

   assign req_port.ready = !q_stat.full;
   assign accept = req_port.valid && req_port.ready;
   assign b = req_port.data_byte;

   always_comb begin
      phase_in      = phase_ff;
      left_in       = left_ff;
      name_seen_in  = name_seen_ff;
      manuf_seen_in = manuf_seen_ff;
      manuf_len_in  = manuf_len_ff;
      pos_in        = pos_ff;
      company_in    = company_ff;
      kind_in       = kind_ff;
      major_in      = major_ff;
      minor_in      = minor_ff;
      walk_done_in  = walk_done_ff;
      ok            = 1'b0;
      rep_major     = '0;
      rep_minor     = '0;
      if (accept) begin
         // capture runs ahead of the walk, on the pre-byte state
         if (manuf_seen_ff && (pos_ff < CAPTURE_LEN)) begin
            case (pos_ff)
               CAP_COMPANY_LO: company_in[7:0]  = b;
               CAP_COMPANY_HI: company_in[15:8] = b;
               CAP_KIND_LO:    kind_in[7:0]     = b;
               CAP_KIND_HI:    kind_in[15:8]    = b;
               CAP_MAJOR_LO:   major_in         = b;
               CAP_MINOR_HI:   minor_in[15:8]   = b;
               CAP_MINOR_LO:   minor_in[7:0]    = b;
               default: ;
            endcase
            pos_in = pos_ff + 1'b1;
         end
         if (!walk_done_ff) begin
            case (phase_ff)
               PH_LEN: begin
                  left_in  = b;
                  phase_in = PH_TYPE;
               end
               PH_TYPE: begin
                  if ((b == TYPE_SHORT_NAME) || (b == TYPE_FULL_NAME)) begin
                     name_seen_in = 1'b1;
                  end else if (b == TYPE_MANUF) begin
                     manuf_seen_in = 1'b1;
                     manuf_len_in  = left_ff - 8'd1;
                     pos_in        = '0;
                     company_in    = '0;
                     kind_in       = '0;
                     major_in      = '0;
                     minor_in      = '0;
                  end
                  if (name_seen_in && manuf_seen_in) begin
                     walk_done_in = 1'b1;
                  end else if (left_ff == 8'd0) begin
                     // zero length: type byte doubles as the next length
                     left_in  = b;
                     phase_in = PH_TYPE;
                  end else if (left_ff == 8'd1) begin
                     left_in  = 8'd0;
                     phase_in = PH_LEN;
                  end else begin
                     left_in  = left_ff - 8'd1;
                     phase_in = PH_SKIP;
                  end
               end
               default: begin
                  if (left_ff != 8'd0) begin
                     left_in = left_ff - 8'd1;
                  end
                  if (left_in == 8'd0) begin
                     phase_in = PH_LEN;
                  end
               end
            endcase
         end
         if (req_port.last_byte) begin
            ok = (req_port.signal_dbm >= min_rssi) && manuf_seen_in
               && (manuf_len_in == MANUF_LEN) && (pos_in == CAPTURE_LEN)
               && (company_in == COMPANY_CODE) && (kind_in == KIND_CODE);
            // report fields are taken before the report state clears
            rep_major     = major_in;
            rep_minor     = minor_in;
            phase_in      = PH_LEN;
            left_in       = '0;
            name_seen_in  = 1'b0;
            manuf_seen_in = 1'b0;
            manuf_len_in  = '0;
            pos_in        = '0;
            company_in    = '0;
            kind_in       = '0;
            major_in      = '0;
            minor_in      = '0;
            walk_done_in  = 1'b0;
         end
      end
   end

   assign push_valid              = ok;
   assign push_item.report_dbm    = req_port.signal_dbm;
   assign push_item.group_code    = rep_major;
   assign push_item.beacon_ident  = rep_minor;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         left_ff       <= '0;
         name_seen_ff  <= 1'b0;
         manuf_seen_ff <= 1'b0;
         manuf_len_ff  <= '0;
         pos_ff        <= '0;
         company_ff    <= '0;
         kind_ff       <= '0;
         major_ff      <= '0;
         minor_ff      <= '0;
         walk_done_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         left_ff       <= left_in;
         name_seen_ff  <= name_seen_in;
         manuf_seen_ff <= manuf_seen_in;
         manuf_len_ff  <= manuf_len_in;
         pos_ff        <= pos_in;
         company_ff    <= company_in;
         kind_ff       <= kind_in;
         major_ff      <= major_in;
         minor_ff      <= minor_in;
         walk_done_ff  <= walk_done_in;
      end
   end

endmodule

>>> hw/rtl/bcls_queue.sv
// ----------------------------------------------------------------------------
// bcls_queue
// Small register queue decoupling the byte walker from the result stage.
// ----------------------------------------------------------------------------
module bcls_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  bcls_pkg::bcls_item_type push_item,
   input  logic                    pop,
   output bcls_pkg::bcls_item_type pop_item,
   output bcls_pkg::q_stat_type    q_stat
);
   import bcls_pkg::*;

   bcls_item_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   assign pop_item         = entries_ff[rd_ptr_ff];
   assign q_stat.count     = count_ff;
   assign q_stat.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_stat.not_empty = (count_ff != '0);

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/bcls_back.sv
// ----------------------------------------------------------------------------
// bcls_back
// Result stage: output register that drains the queue onto the rsp channel.
// ----------------------------------------------------------------------------
module bcls_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bcls_pkg::q_stat_type    q_stat,
   input  bcls_pkg::bcls_item_type pop_item,
   output logic                    pop,
   bcls_rsp_if.source              rsp_port
);
   import bcls_pkg::*;

   logic          out_valid_ff, out_valid_in;
   bcls_item_type out_item_ff;

   // load when the register is empty or its beat leaves this cycle
   assign pop = q_stat.not_empty && (!out_valid_ff || rsp_port.ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.report_dbm   = out_item_ff.report_dbm;
   assign rsp_port.group_code   = out_item_ff.group_code;
   assign rsp_port.beacon_ident = out_item_ff.beacon_ident;

   always_ff @(posedge clock) begin
      if (pop) begin
         out_item_ff <= pop_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
